@@ hdl/emrg_pkg.sv @@
// Shared types and constants for the Eller maze row generator.
// No dependencies; imported by the controller, the datapath and the top level.
package emrg_pkg;

    localparam int MAX_COLS = 32;
    localparam int COL_W    = $clog2(MAX_COLS);
    localparam int NCOL_W   = $clog2(MAX_COLS + 1);
    localparam int LABEL_W  = 6;
    localparam int ROW_W    = 12;
    localparam int RCNT_W   = 13;
    localparam int RR_W     = 31;
    localparam int IN_W     = 64;
    localparam int OUT_W    = 80;

    // Configuration register indexes
    localparam logic [0:0] REG_ROW_COUNT    = 1'b0;
    localparam logic [0:0] REG_COLUMN_COUNT = 1'b1;

    // Datapath operations issued by the controller
    typedef enum logic [3:0] {
        OP_NOP,
        OP_LOAD,
        OP_FRESH,
        OP_MERGE,
        OP_BOT1,
        OP_BOT2,
        OP_CLEAR,
        OP_CANON,
        OP_FINISH
    } dp_op_t;

    typedef struct packed {
        dp_op_t           op;
        logic [COL_W-1:0] col;
    } dp_cmd_t;

    typedef struct packed {
        logic [COL_W-1:0] last_col;
        logic             last_row;
    } dp_status_t;

endpackage

@@ hdl/emrg_ctrl.sv @@
// Sequencer for the Eller maze row generator: walks the column passes of one row.
// Depends on emrg_pkg; drives the datapath through dp_cmd_t, reads dp_status_t.
module emrg_ctrl
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output emrg_pkg::dp_cmd_t    cmd,
    input  emrg_pkg::dp_status_t status
);
    import emrg_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FRESH,
        ST_MERGE,
        ST_BOT1,
        ST_BOT2,
        ST_CLEAR,
        ST_CANON,
        ST_OUT
    } state_t;

    state_t           state_reg, state_next;
    logic [COL_W-1:0] col_reg, col_next;
    logic             out_valid_reg, out_valid_next;
    logic             pass_end;

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = out_valid_reg;
    assign pass_end = (col_reg == status.last_col);

    // Next state, column counter and datapath command
    always_comb
    begin
        state_next     = state_reg;
        col_next       = col_reg;
        out_valid_next = out_valid_reg && !m_tready;
        cmd.op         = OP_NOP;
        cmd.col        = col_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd.op     = OP_LOAD;
                    col_next   = '0;
                    state_next = ST_FRESH;
                end
            end
            ST_FRESH:
            begin
                cmd.op   = OP_FRESH;
                col_next = '0;
                if (status.last_col != '0)
                    state_next = ST_MERGE;
                else
                    state_next = status.last_row ? ST_OUT : ST_BOT1;
            end
            ST_MERGE:
            begin
                cmd.op = OP_MERGE;
                if (col_reg == status.last_col - COL_W'(1))
                begin
                    col_next   = '0;
                    state_next = status.last_row ? ST_OUT : ST_BOT1;
                end
                else
                    col_next = col_reg + COL_W'(1);
            end
            ST_BOT1:
            begin
                cmd.op = OP_BOT1;
                if (pass_end)
                begin
                    col_next   = '0;
                    state_next = ST_BOT2;
                end
                else
                    col_next = col_reg + COL_W'(1);
            end
            ST_BOT2:
            begin
                cmd.op = OP_BOT2;
                if (pass_end)
                begin
                    col_next   = '0;
                    state_next = ST_CLEAR;
                end
                else
                    col_next = col_reg + COL_W'(1);
            end
            ST_CLEAR:
            begin
                cmd.op     = OP_CLEAR;
                col_next   = '0;
                state_next = ST_CANON;
            end
            ST_CANON:
            begin
                cmd.op = OP_CANON;
                if (pass_end)
                begin
                    col_next   = '0;
                    state_next = ST_OUT;
                end
                else
                    col_next = col_reg + COL_W'(1);
            end
            ST_OUT:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    cmd.op         = OP_FINISH;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Hold state, column counter and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            col_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            col_reg       <= col_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

@@ hdl/emrg_datapath.sv @@
// Datapath of the Eller maze row generator: set labels, wall masks, row counter.
// Depends on emrg_pkg; runs one operation per cycle as commanded by emrg_ctrl.
module emrg_datapath
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  emrg_pkg::dp_cmd_t           cmd,
    output emrg_pkg::dp_status_t        status,
    input  logic [emrg_pkg::IN_W-1:0]   in_data,
    input  logic                        cfg_write,
    input  logic [0:0]                  cfg_index,
    input  logic [emrg_pkg::RCNT_W-1:0] cfg_data,
    output logic [emrg_pkg::OUT_W-1:0]  out_data,
    output logic                        out_last
);
    import emrg_pkg::*;

    // Labels follow the rule: label = lowest column of the set + 1
    logic [LABEL_W-1:0]  labels_reg [MAX_COLS];
    logic [RCNT_W-1:0]   row_count_reg;
    logic [NCOL_W-1:0]   column_count_reg;
    logic [ROW_W-1:0]    row_cnt_reg;
    logic [RR_W-1:0]     rr_reg;
    logic [MAX_COLS-1:0] br_reg;
    logic [MAX_COLS-1:0] right_reg;
    logic [MAX_COLS-1:0] bottom_reg;
    logic [MAX_COLS-1:0] done_reg;
    logic [ROW_W-1:0]    out_row_reg;
    logic [MAX_COLS-1:0] out_right_reg;
    logic [MAX_COLS-1:0] out_bottom_reg;
    logic                out_last_reg;

    logic [NCOL_W-1:0]   ncols;
    logic [ROW_W-1:0]    rows_m1;
    logic [MAX_COLS-1:0] colmask;
    logic [MAX_COLS-1:0] colbit;
    logic [COL_W-1:0]    col_p1;
    logic [LABEL_W-1:0]  lab_a, lab_b, keep, gone, key;
    logic [MAX_COLS-1:0] eq;
    logic                last_row;

    // Clamp configuration to the ranges in use
    always_comb
    begin
        if (column_count_reg == '0)
            ncols = NCOL_W'(1);
        else if (column_count_reg > NCOL_W'(MAX_COLS))
            ncols = NCOL_W'(MAX_COLS);
        else
            ncols = column_count_reg;
        if (row_count_reg == '0)
            rows_m1 = '0;
        else if (row_count_reg > RCNT_W'(4096))
            rows_m1 = '1;
        else
            rows_m1 = row_count_reg[ROW_W-1:0] - ROW_W'(1);
    end

    assign last_row        = (row_cnt_reg >= rows_m1);
    assign status.last_col = COL_W'(ncols - NCOL_W'(1));
    assign status.last_row = last_row;

    // Column mask and per-column compare against the selected set
    assign col_p1 = cmd.col + COL_W'(1);
    assign colbit = MAX_COLS'(1) << cmd.col;
    assign lab_a  = labels_reg[cmd.col];
    assign lab_b  = labels_reg[col_p1];
    assign keep   = (lab_a < lab_b) ? lab_a : lab_b;
    assign gone   = (lab_a < lab_b) ? lab_b : lab_a;
    assign key    = (cmd.op == OP_MERGE) ? gone : lab_a;

    always_comb
    begin
        for (int k = 0; k < MAX_COLS; k++)
        begin
            colmask[k] = (NCOL_W'(k) < ncols);
            eq[k]      = colmask[k] && (labels_reg[k] == key);
        end
    end

    // Control state: configuration, labels, row counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_count_reg    <= RCNT_W'(16);
            column_count_reg <= NCOL_W'(16);
            row_cnt_reg      <= '0;
            for (int k = 0; k < MAX_COLS; k++)
                labels_reg[k] <= '0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_ROW_COUNT:    row_count_reg    <= cfg_data;
                REG_COLUMN_COUNT: column_count_reg <= cfg_data[NCOL_W-1:0];
                default:          ;
            endcase
            row_cnt_reg <= '0;
            for (int k = 0; k < MAX_COLS; k++)
                labels_reg[k] <= '0;
        end
        else
        begin
            unique case (cmd.op)
                OP_FRESH:
                begin
                    for (int k = 0; k < MAX_COLS; k++)
                        if (colmask[k] && labels_reg[k] == '0)
                            labels_reg[k] <= LABEL_W'(k + 1);
                end
                OP_MERGE:
                begin
                    if (!(lab_a == lab_b || (!last_row && rr_reg[cmd.col])))
                        for (int k = 0; k < MAX_COLS; k++)
                            if (eq[k])
                                labels_reg[k] <= keep;
                end
                OP_CLEAR:
                begin
                    for (int k = 0; k < MAX_COLS; k++)
                        if (bottom_reg[k])
                            labels_reg[k] <= '0;
                end
                OP_CANON:
                begin
                    if (!done_reg[cmd.col] && lab_a != '0)
                        for (int k = 0; k < MAX_COLS; k++)
                            if (eq[k])
                                labels_reg[k] <= LABEL_W'(cmd.col) + LABEL_W'(1);
                end
                OP_FINISH:
                begin
                    if (last_row)
                    begin
                        row_cnt_reg <= '0;
                        for (int k = 0; k < MAX_COLS; k++)
                            labels_reg[k] <= '0;
                    end
                    else
                        row_cnt_reg <= row_cnt_reg + ROW_W'(1);
                end
                default: ;
            endcase
        end
    end

    // Row payload: random bits, wall masks, output register
    always_ff @(posedge clk)
    begin
        unique case (cmd.op)
            OP_LOAD:
            begin
                rr_reg     <= in_data[RR_W-1:0];
                br_reg     <= in_data[RR_W +: MAX_COLS];
                right_reg  <= '0;
                bottom_reg <= '0;
                done_reg   <= '0;
            end
            OP_MERGE:
            begin
                if (lab_a == lab_b || (!last_row && rr_reg[cmd.col]))
                    right_reg <= right_reg | colbit;
            end
            OP_BOT1:
            begin
                if (br_reg[cmd.col] && ((eq & ~colbit) != '0))
                    bottom_reg <= bottom_reg | colbit;
            end
            OP_BOT2:
            begin
                if ((eq & ~bottom_reg) == '0)
                    bottom_reg <= bottom_reg & ~colbit;
            end
            OP_CANON:
            begin
                if (!done_reg[cmd.col] && lab_a != '0)
                    done_reg <= done_reg | eq;
            end
            OP_FINISH:
            begin
                out_row_reg    <= row_cnt_reg;
                out_right_reg  <= (right_reg | (MAX_COLS'(1) << status.last_col)) & colmask;
                out_bottom_reg <= last_row ? colmask : (bottom_reg & colmask);
                out_last_reg   <= last_row;
            end
            default: ;
        endcase
    end

    assign out_data = {(OUT_W - ROW_W - 2 * MAX_COLS)'(0),
                       out_bottom_reg, out_right_reg, out_row_reg};
    assign out_last = out_last_reg;

endmodule

@@ hdl/eller_maze_row_generator.sv @@
// Top level of the Eller maze row generator: one maze row per input transaction.
// Depends on emrg_pkg, emrg_ctrl and emrg_datapath.
//
//  channel  | direction | payload
//  ---------+-----------+---------------------------------------------------
//  s_*      | in        | random bits for one row
//  m_*      | out       | row index and wall masks, tlast on the final row
//  cfg_*    | in        | register index and write data
//
// A row over N columns runs through the accept step, fresh labels, the merge walk
// (N-1 steps), two bottom-wall walks, a label clear, a relabel walk and the output
// step, each walk stepping one column a cycle; the final row goes from the merge
// walk straight to the output step.
// After reset labels and the row counter are zero; a register write restarts
// the maze. A stalled result waits in the output register while the next row runs.
module eller_maze_row_generator
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [emrg_pkg::IN_W-1:0]    s_tdata,   // right_random[30:0], bottom_random[62:31]
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [emrg_pkg::OUT_W-1:0]   m_tdata,   // row_index[11:0], right_walls[43:12],
                                                    // bottom_walls[75:44]
    output logic                         m_tlast,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [0:0]                   cfg_index,
    input  logic [emrg_pkg::RCNT_W-1:0]  cfg_data
);
    import emrg_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t status;

    // The user must send writes only while idle; the block leaves this unchecked and takes them at once
    assign cfg_ready = 1'b1;

    emrg_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd),
        .status   (status)
    );

    emrg_datapath u_datapath
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .in_data   (s_tdata),
        .cfg_write (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .out_data  (m_tdata),
        .out_last  (m_tlast)
    );

`ifndef NO_ASSERTIONS
    // An accepted row leaves the idle state at once
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input accepted twice in a row");

    // Finishing a row always presents a result
    a_finish_valid: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.op == OP_FINISH |=> m_tvalid)
        else $error("finished row not presented");

    // Every presented row has its right border wall
    a_right_border: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[43:12] != '0)
        else $error("row without right border wall");
`endif

endmodule
